>>> rtl/dpe_pkg.sv
// Shared types and constants for the DPCM prefix-code encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package dpe_pkg;

  typedef struct packed {
    logic [7:0] sample;
    logic       last_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_kind;
    logic       last_byte;
  } out_item_t;

  // Item handed from the front part to the bit packer
  typedef struct packed {
    logic        raw;
    logic [6:0]  raw_val;
    logic [10:0] code;
    logic [3:0]  nbits;
    logic        last;
  } cmd_t;

  localparam int unsigned ACC_W = 18;
  localparam int unsigned CNT_W = 5;

  localparam logic KIND_RAW    = 1'b0;
  localparam logic KIND_PACKED = 1'b1;

  localparam logic [1:0] PFX_TWO   = 2'b10;
  localparam logic [2:0] PFX_FOUR  = 3'b110;
  localparam logic [2:0] PFX_EIGHT = 3'b111;
  localparam logic [7:0] BASE_FOUR  = 8'd6;
  localparam logic [7:0] BASE_EIGHT = 8'd22;

  localparam logic REG_CHANNELS = 1'b0;

endpackage
`default_nettype wire

>>> rtl/dpe_front.sv
// Front part: channel tracking, first-pixel detection, DPCM difference,
// zigzag fold and prefix code selection. Depends on dpe_pkg.
`default_nettype none
module dpe_front
  import dpe_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 3
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic [1:0] channels,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd_data
);

  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [2:0] MAX_EFF = 3'(MAX_CHANNELS);

  logic [6:0] prev_r [MAX_CHANNELS];
  logic [6:0] prev_nxt [MAX_CHANNELS];
  logic [1:0] first_seen_r, first_seen_nxt;
  logic [1:0] ch_idx_r, ch_idx_nxt;

  logic [2:0] eff;
  logic [1:0] ch;
  logic [6:0] halved;
  logic [7:0] diff, y;
  logic       is_raw;
  logic       accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = cmd_ready;
  assign cmd_valid = in_valid;
  assign halved   = in_data.sample[7:1];

  always_comb begin
    if (channels == 2'd0) begin
      eff = 3'd1;
    end else if ({1'b0, channels} > MAX_EFF) begin
      eff = MAX_EFF;
    end else begin
      eff = {1'b0, channels};
    end
    ch     = ({1'b0, ch_idx_r} >= eff) ? 2'd0 : ch_idx_r;
    is_raw = {1'b0, first_seen_r} < eff;
    diff   = {1'b0, halved} - {1'b0, prev_r[ch[CW-1:0]]};
    y      = diff[7] ? ~{diff[6:0], 1'b0} : {diff[6:0], 1'b0};
  end

  always_comb begin
    cmd_data.raw     = is_raw;
    cmd_data.raw_val = halved;
    cmd_data.last    = in_data.last_sample;
    if (y < 8'd2) begin
      cmd_data.code  = {10'd0, y[0]};
      cmd_data.nbits = 4'd2;
    end else if (y < BASE_FOUR) begin
      cmd_data.code  = {7'd0, PFX_TWO, 2'(y - 8'd2)};
      cmd_data.nbits = 4'd4;
    end else if (y < BASE_EIGHT) begin
      cmd_data.code  = {4'd0, PFX_FOUR, 4'(y - BASE_FOUR)};
      cmd_data.nbits = 4'd7;
    end else begin
      cmd_data.code  = {PFX_EIGHT, y - BASE_EIGHT};
      cmd_data.nbits = 4'd11;
    end
  end

  always_comb begin
    prev_nxt       = prev_r;
    first_seen_nxt = first_seen_r;
    ch_idx_nxt     = ch_idx_r;
    if (accept) begin
      prev_nxt[ch[CW-1:0]] = halved;
      if (is_raw) begin
        first_seen_nxt = first_seen_r + 2'd1;
      end
      ch_idx_nxt = ({1'b0, ch} + 3'd1 >= eff) ? 2'd0 : ch + 2'd1;
      if (in_data.last_sample) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          prev_nxt[i] = 7'd0;
        end
        first_seen_nxt = 2'd0;
        ch_idx_nxt     = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        prev_r[i] <= 7'd0;
      end
      first_seen_r <= 2'd0;
      ch_idx_r     <= 2'd0;
    end else begin
      prev_r       <= prev_nxt;
      first_seen_r <= first_seen_nxt;
      ch_idx_r     <= ch_idx_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dpe_cmd_queue.sv
// Two-entry queue of coded items between the front part and the packer.
// Depends on dpe_pkg.
`default_nettype none
module dpe_cmd_queue
  import dpe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_data
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dpe_back.sv
// Back part: bit packer, one output byte per cycle when the output is free,
// flush on the last item, output register. Depends on dpe_pkg.
`default_nettype none
module dpe_back
  import dpe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cmd_valid,
  output logic       cmd_ready,
  input  wire cmd_t  cmd_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  logic             active_r, active_nxt;
  logic             raw_r, raw_nxt;
  logic             last_r, last_nxt;
  logic [6:0]       raw_val_r, raw_val_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             slot_free, emit, s_done;
  logic             s_raw;
  logic [ACC_W-1:0] s_acc, b_acc, p_acc;
  logic [CNT_W-1:0] s_cnt, b_cnt, p_cnt;
  logic [7:0]       s_byte;
  logic             s_kind;
  logic             pop, work;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = active_r && slot_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    s_raw  = 1'b0;
    s_acc  = acc_r;
    s_cnt  = cnt_r;
    s_kind = KIND_PACKED;
    if (raw_r) begin
      s_byte = {1'b0, raw_val_r};
      s_kind = KIND_RAW;
    end else if (cnt_r >= CNT_W'(8)) begin
      s_byte = 8'(acc_r >> (cnt_r - CNT_W'(8)));
      s_cnt  = cnt_r - CNT_W'(8);
    end else begin
      s_byte = 8'(acc_r << (CNT_W'(8) - cnt_r));
      s_cnt  = '0;
    end
    s_done = !s_raw && (s_cnt < CNT_W'(8)) && !(last_r && s_cnt != '0);
  end

  assign cmd_ready = !active_r || (emit && s_done);
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    if (emit) begin
      b_acc = s_acc;
      b_cnt = (s_done && last_r) ? '0 : s_cnt;
    end else begin
      b_acc = acc_r;
      b_cnt = cnt_r;
    end
    if (cmd_data.raw) begin
      p_acc = b_acc;
      p_cnt = b_cnt;
    end else begin
      p_acc = (b_acc << cmd_data.nbits) | ACC_W'(cmd_data.code);
      p_cnt = b_cnt + CNT_W'(cmd_data.nbits);
    end
    work = cmd_data.raw || (p_cnt >= CNT_W'(8)) || (cmd_data.last && p_cnt != '0);
  end

  always_comb begin
    active_nxt  = active_r;
    raw_nxt     = raw_r;
    last_nxt    = last_r;
    raw_val_nxt = raw_val_r;
    acc_nxt     = b_acc;
    cnt_nxt     = b_cnt;
    if (emit) begin
      raw_nxt    = s_raw;
      active_nxt = !s_done;
    end
    if (pop) begin
      active_nxt  = work;
      raw_nxt     = cmd_data.raw;
      last_nxt    = cmd_data.last;
      raw_val_nxt = cmd_data.raw_val;
      acc_nxt     = p_acc;
      cnt_nxt     = (!work && cmd_data.last) ? '0 : p_cnt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt      = 1'b1;
      out_nxt.out_byte   = s_byte;
      out_nxt.byte_kind  = s_kind;
      out_nxt.last_byte  = last_r && s_done;
    end
  end

  always_ff @(posedge clk) begin
    raw_val_r <= raw_val_nxt;
    acc_r     <= acc_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      raw_r       <= 1'b0;
      last_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      raw_r       <= raw_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> cnt_r < CNT_W'(8))
    else $error("idle packer holds a full byte");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_r && s_done) |=> (cnt_r == '0 || active_r))
    else $error("pending bits survive the last byte");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !emit) |-> !cmd_ready)
    else $error("item taken while packer busy");

  a_raw_first: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && raw_r) |=> out_valid_r && out_r.byte_kind == KIND_RAW)
    else $error("raw byte lost");

endmodule
`default_nettype wire

>>> rtl/dpcm_prefix_code_encoder_top.sv
// DPCM prefix-code encoder: input, configuration register and output stage.
// Uses dpe_pkg, dpe_front, dpe_cmd_queue and dpe_back.
//
// Usage:
//   in_valid/in_ready/in_data carry one 8-bit sample and a last flag.
//   out_valid/out_ready/out_data carry one byte, its kind (raw or packed)
//   and a last-byte flag; the final byte of an image has last_byte set.
//   The APB port holds one register, channels, at byte address 0; write it
//   only while the block is idle.
//   Each sample is coded in the cycle it is taken and queued; the packer
//   emits one byte per cycle while the output register is free, zero to
//   three bytes per sample; it takes a new item only when idle or with
//   the last byte of the current one. From acceptance, a sample passes
//   the queue, packer state and output register before its first byte.
//   Reset clears the channel history, the partial byte and the queue and
//   sets channels to 1. When the receiver stalls, the output register holds
//   and the two-entry queue fills, after which in_ready drops.
`default_nettype none
module dpcm_prefix_code_encoder_top
  import dpe_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0] channels_r, channels_nxt;
  logic       f_valid, f_ready;
  cmd_t       f_data;
  logic       q_valid, q_ready;
  cmd_t       q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHANNELS) ? {30'd0, channels_r} : 32'd0;

  always_comb begin
    channels_nxt = channels_r;
    if (psel && penable && pwrite && paddr[2] == REG_CHANNELS) begin
      channels_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r <= 2'd1;
    end else begin
      channels_r <= channels_nxt;
    end
  end

  dpe_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .channels (channels_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd_data (f_data)
  );

  dpe_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_data),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  dpe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd_data (q_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
